// ===== rtl/gas_pkg.sv =====
// Package: mode and turn codes, and register indexes for the gate approach sequencer.
package gas_pkg;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_ALIGN  = 2'd1,
        MODE_FLY    = 2'd2,
        MODE_BLIND  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        TURN_NONE        = 3'd0,
        TURN_SEARCH      = 3'd1,
        TURN_ALIGN_LEFT  = 3'd2,
        TURN_ALIGN_RIGHT = 3'd3,
        TURN_FLY_LEFT    = 3'd4,
        TURN_FLY_RIGHT   = 3'd5
    } t_turn;

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ALIGN_TOL   = 3'd0;
    localparam t_cfg_idx CFG_MAX_AGE     = 3'd1;
    localparam t_cfg_idx CFG_APPROACH    = 3'd2;
    localparam t_cfg_idx CFG_CENTERED    = 3'd3;
    localparam t_cfg_idx CFG_CORR_STRIDE = 3'd4;
    localparam t_cfg_idx CFG_BLIND       = 3'd5;

    localparam logic [14:0] RST_ALIGN_TOL   = 15'd10;
    localparam logic [15:0] RST_MAX_AGE     = 16'd3;
    localparam logic [15:0] RST_APPROACH    = 16'd8;
    localparam logic [15:0] RST_CENTERED    = 16'd3;
    localparam logic [15:0] RST_CORR_STRIDE = 16'd1;
    localparam logic [7:0]  RST_BLIND       = 8'd10;

    localparam logic [15:0] SAT16 = 16'hFFFF;

endpackage

// ===== rtl/gate_approach_sequencer_core.sv =====
// Gate approach sequencer: message/tick step logic, state and result register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  in       | input     | i_in_valid / o_in_stall    | opcode, in_flight, pixel_x,
//           |           |                            | image_width, quality
//  out      | output    | o_out_valid / i_out_stall  | mode, turn_command, advance,
//           |           |                            | error_x, gate_good
//  cfg      | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One beat in, one beat out; the step is computed in the accepting cycle and the
// result appears in the output register on the next cycle (rate 1/cycle while the output is not stalled).
// A new beat is accepted whenever the output register is empty or is being taken.
// Synchronous active-low reset returns config, state and output valid to defaults; output payload is not reset.
// An output stall holds the result and stalls the input only while the result waits.
module gate_approach_sequencer_core
    import gas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic                  i_in_flight,
    input  logic signed [15:0]    i_pixel_x,
    input  logic signed [15:0]    i_image_width,
    input  logic signed [31:0]    i_quality,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_mode,
    output logic [2:0]            o_turn_command,
    output logic                  o_advance,
    output logic signed [15:0]    o_error_x,
    output logic                  o_gate_good,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [14:0] r_align_tol;
    logic [15:0] r_max_age;
    logic [15:0] r_approach;
    logic [15:0] r_centered;
    logic [15:0] r_corr_stride;
    logic [7:0]  r_blind_ticks;

    t_mode              r_mode,        n_mode;
    logic [31:0]        r_tick_cnt,    n_tick_cnt;
    logic [31:0]        r_msg_cnt,     n_msg_cnt;
    logic [31:0]        r_last_msg,    n_last_msg;
    logic [31:0]        r_last_corr,   n_last_corr;
    logic [15:0]        r_fly_good,    n_fly_good;
    logic [15:0]        r_fly_cent,    n_fly_cent;
    logic [7:0]         r_blind_rem,   n_blind_rem;
    logic               r_gate_seen,   n_gate_seen;
    logic               r_geom_ok,     n_geom_ok;
    logic signed [15:0] r_gate_x,      n_gate_x;
    logic signed [15:0] r_width,       n_width;

    logic               r_out_valid;
    t_mode              r_out_mode;
    t_turn              r_out_turn,    n_turn;
    logic               r_out_adv,     n_adv;
    logic signed [15:0] r_out_err,     n_err;
    logic               r_out_good,    n_good;

    logic               accept;
    logic               seen;
    logic               ok;
    logic [31:0]        age;
    logic               good_now;
    logic signed [16:0] err_full;
    logic signed [16:0] tol;
    logic               err_low;
    logic               err_high;
    logic [15:0]        fg_inc;
    logic [15:0]        fc_inc;
    logic [7:0]         br_dec;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign tol      = $signed({2'b00, r_align_tol});
    assign err_full = r_geom_ok ? ($signed({r_gate_x[15], r_gate_x})
                                   - $signed({2'b00, r_width[15:1]})) : 17'sd0;
    assign err_low  = err_full < -tol;
    assign err_high = err_full > tol;

    always_comb begin
        n_mode      = r_mode;
        n_tick_cnt  = r_tick_cnt;
        n_msg_cnt   = r_msg_cnt;
        n_last_msg  = r_last_msg;
        n_last_corr = r_last_corr;
        n_fly_good  = r_fly_good;
        n_fly_cent  = r_fly_cent;
        n_blind_rem = r_blind_rem;
        n_gate_seen = r_gate_seen;
        n_geom_ok   = r_geom_ok;
        n_gate_x    = r_gate_x;
        n_width     = r_width;
        n_turn      = TURN_NONE;
        n_adv       = 1'b0;
        n_err       = err_full[15:0];
        n_good      = 1'b0;

        seen   = !i_quality[31] && (i_quality != 32'sd0);
        ok     = (i_image_width > 16'sd1)
                 && !(seen && (i_pixel_x[15] || (i_pixel_x >= i_image_width)));
        fg_inc = (r_fly_good == SAT16) ? SAT16 : r_fly_good + 16'd1;
        fc_inc = (r_fly_cent == SAT16) ? SAT16 : r_fly_cent + 16'd1;
        br_dec = (r_blind_rem != 8'd0) ? r_blind_rem - 8'd1 : 8'd0;

        if (i_opcode == OP_TICK && i_in_flight) begin
            n_tick_cnt = r_tick_cnt + 32'd1;
        end
        age      = n_tick_cnt - r_last_msg;
        good_now = (age <= {16'd0, r_max_age}) && r_geom_ok && r_gate_seen;

        if (i_opcode == OP_MESSAGE) begin
            n_gate_x    = i_pixel_x;
            n_width     = i_image_width;
            n_gate_seen = seen;
            n_geom_ok   = ok;
            n_msg_cnt   = r_msg_cnt + 32'd1;
            n_last_msg  = r_tick_cnt;
            n_good      = ok && seen;
            n_err       = ok ? (i_pixel_x - {1'b0, i_image_width[15:1]}) : 16'sd0;
        end else begin
            n_good = good_now;
            if (i_in_flight) begin
                case (r_mode)
                    MODE_SEARCH: begin
                        n_turn = TURN_SEARCH;
                        if (good_now) begin
                            n_mode = MODE_ALIGN;
                        end
                    end
                    MODE_ALIGN: begin
                        if (!good_now) begin
                            n_fly_cent = 16'd0;
                            n_mode     = MODE_SEARCH;
                        end else if (err_low) begin
                            n_turn = TURN_ALIGN_LEFT;
                        end else if (err_high) begin
                            n_turn = TURN_ALIGN_RIGHT;
                        end else begin
                            n_fly_good  = 16'd0;
                            n_fly_cent  = 16'd0;
                            n_last_corr = r_msg_cnt;
                            n_mode      = MODE_FLY;
                        end
                    end
                    MODE_FLY: begin
                        if (!good_now) begin
                            n_fly_good = 16'd0;
                            n_fly_cent = 16'd0;
                            n_mode     = MODE_SEARCH;
                        end else begin
                            n_fly_good = fg_inc;
                            n_fly_cent = (err_low || err_high) ? 16'd0 : fc_inc;
                            if ((r_msg_cnt - r_last_corr) >= {16'd0, r_corr_stride}) begin
                                if (err_low) begin
                                    n_turn      = TURN_FLY_LEFT;
                                    n_last_corr = r_msg_cnt;
                                end else if (err_high) begin
                                    n_turn      = TURN_FLY_RIGHT;
                                    n_last_corr = r_msg_cnt;
                                end
                            end
                            if (n_fly_good >= r_approach && n_fly_cent >= r_centered) begin
                                n_blind_rem = r_blind_ticks;
                                n_mode      = MODE_BLIND;
                            end else begin
                                n_adv = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_adv       = 1'b1;
                        n_blind_rem = br_dec;
                        if (br_dec == 8'd0) begin
                            n_fly_good = 16'd0;
                            n_fly_cent = 16'd0;
                            n_mode     = MODE_SEARCH;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_tol   <= RST_ALIGN_TOL;
            r_max_age     <= RST_MAX_AGE;
            r_approach    <= RST_APPROACH;
            r_centered    <= RST_CENTERED;
            r_corr_stride <= RST_CORR_STRIDE;
            r_blind_ticks <= RST_BLIND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALIGN_TOL:   r_align_tol   <= i_cfg_data[14:0];
                CFG_MAX_AGE:     r_max_age     <= i_cfg_data;
                CFG_APPROACH:    r_approach    <= i_cfg_data;
                CFG_CENTERED:    r_centered    <= i_cfg_data;
                CFG_CORR_STRIDE: r_corr_stride <= i_cfg_data;
                CFG_BLIND:       r_blind_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SEARCH;
            r_tick_cnt  <= 32'd0;
            r_msg_cnt   <= 32'd0;
            r_last_msg  <= 32'd0;
            r_last_corr <= 32'd0;
            r_fly_good  <= 16'd0;
            r_fly_cent  <= 16'd0;
            r_blind_rem <= 8'd0;
            r_gate_seen <= 1'b0;
            r_geom_ok   <= 1'b0;
            r_gate_x    <= 16'sd0;
            r_width     <= 16'sd0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_tick_cnt  <= n_tick_cnt;
            r_msg_cnt   <= n_msg_cnt;
            r_last_msg  <= n_last_msg;
            r_last_corr <= n_last_corr;
            r_fly_good  <= n_fly_good;
            r_fly_cent  <= n_fly_cent;
            r_blind_rem <= n_blind_rem;
            r_gate_seen <= n_gate_seen;
            r_geom_ok   <= n_geom_ok;
            r_gate_x    <= n_gate_x;
            r_width     <= n_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_mode <= n_mode;
            r_out_turn <= n_turn;
            r_out_adv  <= n_adv;
            r_out_err  <= n_err;
            r_out_good <= n_good;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode         = r_out_mode;
    assign o_turn_command = r_out_turn;
    assign o_advance      = r_out_adv;
    assign o_error_x      = r_out_err;
    assign o_gate_good    = r_out_good;

endmodule
